@@ rtl/lmte_pkg.sv @@
// Package for the list marker text encoder.
// Word types, character codes and Roman numeral tables; no dependencies.
package lmte_pkg;

    typedef struct packed {
        logic [2:0]  style;
        logic [31:0] index;
    } item_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } result_t;

    localparam logic [2:0] STYLE_NONE    = 3'd0;
    localparam logic [2:0] STYLE_DECIMAL = 3'd1;
    localparam logic [2:0] STYLE_LEAD0   = 3'd2;
    localparam logic [2:0] STYLE_LROMAN  = 3'd3;
    localparam logic [2:0] STYLE_UROMAN  = 3'd4;
    localparam logic [2:0] STYLE_LALPHA  = 3'd5;
    localparam logic [2:0] STYLE_UALPHA  = 3'd6;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_CASE_OFS = 8'h20;

    localparam logic [5:0] BASE_DEC   = 6'd10;
    localparam logic [5:0] BASE_ALPHA = 6'd26;

    // Number of Roman symbols that one decimal digit expands to
    function automatic logic [2:0] roman_len(input logic [4:0] d);
        logic [2:0] n;
        case (d)
            5'd0:    n = 3'd0;
            5'd1:    n = 3'd1;
            5'd2:    n = 3'd2;
            5'd3:    n = 3'd3;
            5'd4:    n = 3'd2;
            5'd5:    n = 3'd1;
            5'd6:    n = 3'd2;
            5'd7:    n = 3'd3;
            5'd8:    n = 3'd4;
            5'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Symbol k of digit d at decimal place p (0 ones .. 3 thousands), lower case
    function automatic logic [7:0] roman_char(input logic [4:0] d, input logic [1:0] p,
                                              input logic [2:0] k);
        logic [7:0] one;
        logic [7:0] five;
        logic [7:0] ten;
        logic [7:0] c;
        case (p)
            2'd0:    begin one = 8'h69; five = 8'h76; ten = 8'h78; end // i v x
            2'd1:    begin one = 8'h78; five = 8'h6C; ten = 8'h63; end // x l c
            2'd2:    begin one = 8'h63; five = 8'h64; ten = 8'h6D; end // c d m
            default: begin one = 8'h6D; five = 8'h6D; ten = 8'h6D; end // m
        endcase
        if (d == 5'd4) begin
            c = (k == 3'd0) ? one : five;
        end
        else if (d == 5'd9) begin
            c = (k == 3'd0) ? one : ten;
        end
        else if (d >= 5'd5) begin
            c = (k == 3'd0) ? five : one;
        end
        else begin
            c = one;
        end
        return c;
    endfunction

endpackage

@@ rtl/lmte_div.sv @@
// Bit-serial restoring divider by 10 or 26, one quotient bit per cycle.
// Uses lmte_pkg for the base constants.
module lmte_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  logic         alpha,
    input  logic [W-1:0] dividend,
    output logic         busy,
    output logic [W-1:0] quotient,
    output logic [4:0]   remainder
);
    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]  quo_reg,  quo_next;
    logic [4:0]    part_reg, part_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          run_reg,  run_next;
    logic          alpha_reg, alpha_next;
    logic [5:0]    trial;
    logic [5:0]    base;
    logic          ge;

    // one shift-subtract step
    always_comb
    begin
        base       = alpha_reg ? lmte_pkg::BASE_ALPHA : lmte_pkg::BASE_DEC;
        trial      = {part_reg, quo_reg[W-1]};
        ge         = (trial >= base);
        quo_next   = quo_reg;
        part_next  = part_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        alpha_next = alpha_reg;
        if (load) begin
            quo_next   = dividend;
            part_next  = 5'd0;
            cnt_next   = '0;
            run_next   = 1'b1;
            alpha_next = alpha;
        end
        else if (run_reg) begin
            part_next = ge ? 5'(trial - base) : trial[4:0];
            quo_next  = {quo_reg[W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1)) begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        part_reg  <= part_next;
        alpha_reg <= alpha_next;
    end

    assign busy      = run_reg;
    assign quotient  = quo_reg;
    assign remainder = part_reg;

endmodule

@@ rtl/list_marker_text_encoder.sv @@
// List marker text encoder: style plus signed index in, ASCII marker text out.
// Steps: the serial divider extracts the digits, least significant first, onto a stack;
// then the marker is emitted character by character from the stack (Roman digits of value zero emit nothing).
// One word at a time: a new start is taken only while idle; style none produces no output.
// Reset (rst_n, async low) returns the sequencer to idle; results cannot be stalled.
// Depends on lmte_pkg and lmte_div.
module list_marker_text_encoder #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lmte_pkg::item_t   item,
    output logic              strobe,
    output lmte_pkg::result_t result
);
    localparam int W         = INDEX_WIDTH;
    localparam int DIG_DEPTH = (W * 301) / 1000 + 1;
    localparam int IDX_W     = $clog2(DIG_DEPTH);
    localparam int CNT_W     = $clog2(DIG_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_PRE0  = 3'd2;
    localparam logic [2:0] S_MINUS = 3'd3;
    localparam logic [2:0] S_DIG   = 3'd4;
    localparam logic [2:0] S_DOT   = 3'd5;

    localparam logic [1:0] M_DEC = 2'd0;
    localparam logic [1:0] M_ROM = 2'd1;
    localparam logic [1:0] M_ALP = 2'd2;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       mode_reg,  mode_next;
    logic             upper_reg, upper_next;
    logic             neg_reg,   neg_next;
    logic             lead0_reg, lead0_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [2:0]       k_reg,     k_next;
    logic [4:0]       digits_reg [DIG_DEPTH];

    logic [W-1:0]     v;
    logic             v_neg;
    logic [W-1:0]     mag;
    logic             roman_ok;
    logic             accept;
    logic             div_load;
    logic             div_alpha;
    logic [W-1:0]     div_dividend;
    logic             div_busy;
    logic [W-1:0]     div_quo;
    logic [4:0]       div_rem;
    logic             push;
    logic [IDX_W-1:0] top;
    logic [4:0]       top_digit;
    logic [2:0]       rlen;
    logic [7:0]       rchar;
    logic [7:0]       letter;
    logic [2:0]       first_emit;

    lmte_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (div_load),
        .alpha     (div_alpha),
        .dividend  (div_dividend),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // decode of the incoming word
    always_comb
    begin
        v        = item.index[W-1:0];
        v_neg    = v[W-1];
        mag      = v_neg ? (~v + 1'b1) : v;
        roman_ok = !v_neg && (v != '0) && (32'(v) <= 32'd3999);
        accept   = start && !busy;
    end

    // digit stack read and character lookup
    always_comb
    begin
        top       = IDX_W'(cnt_reg - 1'b1);
        top_digit = digits_reg[top];
        rlen      = lmte_pkg::roman_len(top_digit);
        rchar     = lmte_pkg::roman_char(top_digit, top[1:0], k_reg);
        letter    = lmte_pkg::CH_LOWER_A + 8'(top_digit);
        first_emit = lead0_reg ? S_PRE0 : (neg_reg ? S_MINUS : S_DIG);
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        upper_next   = upper_reg;
        neg_next     = neg_reg;
        lead0_next   = lead0_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        div_load     = 1'b0;
        div_alpha    = (mode_reg == M_ALP);
        div_dividend = div_quo;
        push         = 1'b0;
        strobe       = 1'b0;
        result.char_code = lmte_pkg::CH_PERIOD;
        result.last      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && item.style inside {[lmte_pkg::STYLE_DECIMAL :
                                                  lmte_pkg::STYLE_UALPHA]}) begin
                    mode_next  = M_DEC;
                    upper_next = 1'b0;
                    if ((item.style == lmte_pkg::STYLE_LROMAN ||
                         item.style == lmte_pkg::STYLE_UROMAN) && roman_ok) begin
                        mode_next  = M_ROM;
                        upper_next = (item.style == lmte_pkg::STYLE_UROMAN);
                    end
                    if ((item.style == lmte_pkg::STYLE_LALPHA ||
                         item.style == lmte_pkg::STYLE_UALPHA) &&
                        !v_neg && (v != '0)) begin
                        mode_next  = M_ALP;
                        upper_next = (item.style == lmte_pkg::STYLE_UALPHA);
                    end
                    neg_next   = v_neg;
                    lead0_next = (item.style == lmte_pkg::STYLE_LEAD0) &&
                                 (v_neg || (32'(v) < 32'd10));
                    div_alpha    = (mode_next == M_ALP);
                    div_dividend = div_alpha ? (v - 1'b1) : mag;
                    div_load     = 1'b1;
                    cnt_next     = '0;
                    k_next       = 3'd0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!div_busy) begin
                    push = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (div_quo == '0) begin
                        state_next = first_emit;
                    end
                    else begin
                        div_dividend = div_alpha ? (div_quo - 1'b1) : div_quo;
                        div_load     = 1'b1;
                    end
                end
            end
            S_PRE0:
            begin
                strobe           = 1'b1;
                result.char_code = lmte_pkg::CH_ZERO;
                state_next       = neg_reg ? S_MINUS : S_DIG;
            end
            S_MINUS:
            begin
                strobe           = 1'b1;
                result.char_code = lmte_pkg::CH_MINUS;
                state_next       = S_DIG;
            end
            S_DIG:
            begin
                if (mode_reg == M_ROM) begin
                    strobe           = (k_reg < rlen);
                    result.char_code = upper_reg ? (rchar - lmte_pkg::CH_CASE_OFS) : rchar;
                    if (k_reg + 3'd1 >= rlen) begin
                        k_next   = 3'd0;
                        cnt_next = cnt_reg - 1'b1;
                        if (cnt_reg == CNT_W'(1)) begin
                            state_next = S_DOT;
                        end
                    end
                    else begin
                        k_next = k_reg + 3'd1;
                    end
                end
                else begin
                    strobe = 1'b1;
                    if (mode_reg == M_ALP) begin
                        result.char_code = upper_reg ? (letter - lmte_pkg::CH_CASE_OFS)
                                                     : letter;
                    end
                    else begin
                        result.char_code = lmte_pkg::CH_ZERO + 8'(top_digit);
                    end
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = S_DOT;
                    end
                end
            end
            S_DOT:
            begin
                strobe           = 1'b1;
                result.char_code = lmte_pkg::CH_PERIOD;
                result.last      = 1'b1;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            k_reg     <= 3'd0;
        end
        else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        upper_reg <= upper_next;
        neg_reg   <= neg_next;
        lead0_reg <= lead0_next;
        if (push && (cnt_reg < CNT_W'(DIG_DEPTH))) begin
            digits_reg[IDX_W'(cnt_reg)] <= div_rem;
        end
    end

`ifndef SYNTHESIS
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("strobe while idle");
    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result.last |-> strobe)
        else $error("last without strobe");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |=> !busy)
        else $error("still busy after final character");
    a_no_emit_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> !strobe)
        else $error("character emitted during digit extraction");
`endif

endmodule
